[design/hat_pkg.sv]
package hat_pkg;

	localparam int TIME_W     = 47;
	localparam int RES_W      = 48;
	localparam int IVL_W      = 24;
	localparam int K_W        = 32;
	localparam int MEAN_W     = 32;
	localparam int PROD_W     = 52;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 47;

	localparam int SHORT_DEPTH_DEF = 16;
	localparam int LONG_DEPTH_DEF  = 64;

	localparam logic [IVL_W-1:0] HB_INTERVAL_RST   = 24'd256000;
	localparam logic [IVL_W-1:0] SAFETY_MARGIN_RST = 24'd256000;
	localparam logic [K_W-1:0]   K_NONE            = 32'hFFFF_FFFF;
	localparam logic [K_W-1:0]   K_MAX             = 32'hFFFF_FFFE;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_TIME_ORIGIN   = 2'd0,
		CFG_HB_INTERVAL   = 2'd1,
		CFG_SAFETY_MARGIN = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic start;
		logic busy;
	} unit_ctl_t;

	function automatic logic signed [RES_W-1:0] sat48(input logic signed [63:0] v);
		logic signed [63:0] hi;
		logic signed [63:0] lo;
		hi = 64'sh0000_7FFF_FFFF_FFFF;
		lo = -64'sh0000_8000_0000_0000;
		if (v > hi) return hi[RES_W-1:0];
		if (v < lo) return lo[RES_W-1:0];
		return v[RES_W-1:0];
	endfunction

	function automatic logic signed [MEAN_W-1:0] sat32(input logic signed [63:0] v);
		logic signed [63:0] hi;
		logic signed [63:0] lo;
		hi = 64'sh0000_0000_7FFF_FFFF;
		lo = -64'sh0000_0000_8000_0000;
		if (v > hi) return hi[MEAN_W-1:0];
		if (v < lo) return lo[MEAN_W-1:0];
		return v[MEAN_W-1:0];
	endfunction

endpackage

[design/hat_ifs.sv]
interface hat_beat_if;
	logic                          valid;
	logic                          ready;
	logic [hat_pkg::TIME_W-1:0]    arrival_time;
	modport source (output valid, output arrival_time, input ready);
	modport sink (input valid, input arrival_time, output ready);
endinterface

interface hat_result_if;
	logic                             valid;
	logic                             ready;
	logic signed [hat_pkg::RES_W-1:0] estimated_arrival;
	logic signed [hat_pkg::RES_W-1:0] expiry_point;
	logic signed [hat_pkg::RES_W-1:0] remaining_timeout;
	logic                             windows_full;
	logic                             index_saturated;
	modport source (output valid, output estimated_arrival, output expiry_point,
		output remaining_timeout, output windows_full, output index_saturated, input ready);
	modport sink (input valid, input estimated_arrival, input expiry_point,
		input remaining_timeout, input windows_full, input index_saturated, output ready);
endinterface

interface hat_cfg_if;
	logic                               valid;
	logic                               ready;
	logic [hat_pkg::CFG_IDX_W-1:0]      index;
	logic [hat_pkg::CFG_DATA_W-1:0]     data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

[design/hat_mul.sv]
// Shift-add multiplier, one multiplier bit per cycle; |product| clamped to 2^50.
module hat_mul (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  hat_pkg::unit_ctl_t                   ctl_in,
	output logic                                 busy,
	input  logic [hat_pkg::K_W-1:0]              a,
	input  logic signed [hat_pkg::MEAN_W-1:0]    b,
	output logic signed [hat_pkg::PROD_W-1:0]    prod
);
	localparam int AW = hat_pkg::K_W;
	localparam int CW = $clog2(AW + 1);
	localparam logic [2*AW-1:0] CLAMP = 64'd1 << 50;

	logic [2*AW-1:0]   p_q;
	logic [AW-1:0]     mag_q;
	logic              neg_q;
	logic [CW-1:0]     cnt_q;
	logic              busy_q;
	logic [AW:0]       sum;
	logic [2*AW-1:0]   clamped;

	assign sum  = {1'b0, p_q[2*AW-1:AW]} + (p_q[0] ? {1'b0, mag_q} : {(AW+1){1'b0}});
	assign busy = busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (ctl_in.start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CW'(AW - 1)) busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl_in.start) begin
			p_q   <= {{AW{1'b0}}, a};
			neg_q <= b[AW-1];
			mag_q <= b[AW-1] ? AW'(-b) : AW'(b);
		end else if (busy_q) begin
			p_q <= {sum, p_q[AW-1:1]};
		end
	end

	always_comb begin
		clamped = (p_q > CLAMP) ? CLAMP : p_q;
		prod = neg_q ? -$signed(clamped[hat_pkg::PROD_W-1:0])
			: $signed(clamped[hat_pkg::PROD_W-1:0]);
	end
endmodule

[design/hat_div.sv]
// Restoring divider, one quotient bit per cycle; quotient floored.
module hat_div #(
	parameter int NW = 56,
	parameter int DW = 7
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  hat_pkg::unit_ctl_t    ctl_in,
	output logic                  busy,
	input  logic signed [NW-1:0]  num,
	input  logic [DW-1:0]         den,
	output logic signed [NW-1:0]  quo
);
	localparam int CW = $clog2(NW + 1);

	logic [NW-1:0] m_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] den_q;
	logic          neg_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic [DW:0]   trial;
	logic          fits;

	assign trial = {rem_q, m_q[NW-1]};
	assign fits  = trial >= {1'b0, den_q};
	assign busy  = busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (ctl_in.start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CW'(NW - 1)) busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl_in.start) begin
			m_q   <= num[NW-1] ? NW'(-num) : NW'(num);
			neg_q <= num[NW-1];
			den_q <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? DW'(trial - {1'b0, den_q}) : trial[DW-1:0];
			m_q   <= {m_q[NW-2:0], fits};
		end
	end

	// negative dividend with remainder: -q-1 == ~q
	always_comb begin
		if (!neg_q)            quo = $signed(m_q);
		else if (rem_q != '0)  quo = $signed(~m_q);
		else                   quo = -$signed(m_q);
	end
endmodule

[design/heartbeat_adaptive_timeout_unit.sv]
// Each result beat follows two serial 32-bit multiplies and the serial window dividers, LSW =
// 48 + clog2(LONG_DEPTH+1) bits wide; the first beat skips the dividers and second multiply.
// One beat in flight; the next is accepted the cycle after the result is loaded. A stalled
// result holds the next beat in its last step.
// Reset (arst_n low, async): no beat seen, sums and mean zero, registers at defaults.
module heartbeat_adaptive_timeout_unit #(
	parameter int SHORT_DEPTH = hat_pkg::SHORT_DEPTH_DEF,
	parameter int LONG_DEPTH  = hat_pkg::LONG_DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	hat_beat_if.sink      beat_in,
	hat_result_if.source  result_out,
	hat_cfg_if.sink       cfg
);
	localparam int RW  = hat_pkg::RES_W;
	localparam int KW  = hat_pkg::K_W;
	localparam int SIW = SHORT_DEPTH > 1 ? $clog2(SHORT_DEPTH) : 1;
	localparam int LIW = LONG_DEPTH > 1 ? $clog2(LONG_DEPTH) : 1;
	localparam int SDW = $clog2(SHORT_DEPTH + 1);
	localparam int LDW = $clog2(LONG_DEPTH + 1);
	localparam int SSW = RW + SDW;
	localparam int LSW = RW + LDW;
	localparam int EW  = (LSW > hat_pkg::PROD_W ? LSW : hat_pkg::PROD_W) + 1;

	typedef enum logic [3:0] {
		ST_IDLE, ST_GAP, ST_MUL1, ST_DIVS, ST_DIV, ST_MUL2S, ST_MUL2,
		ST_EST, ST_FRESH, ST_TMO, ST_OUT
	} state_t;

	state_t state_q;

	logic [hat_pkg::TIME_W-1:0] origin_q;
	logic [hat_pkg::IVL_W-1:0]  hb_ivl_q;
	logic [hat_pkg::IVL_W-1:0]  margin_q;

	logic [KW-1:0]                     k_q;
	logic [SIW-1:0]                    idx_s_q;
	logic [LIW-1:0]                    idx_l_q;
	logic signed [RW-1:0]              last_q;
	logic signed [hat_pkg::MEAN_W-1:0] mean_q;
	logic signed [SSW-1:0]             ssum_q;
	logic signed [LSW-1:0]             lsum_q;
	logic signed [LSW-1:0]             gsum_q;
	logic                              full_q;
	logic                              sat_q;
	logic                              out_valid_q;

	logic signed [RW-1:0]  t_q, gap_q, rd_s_q, rd_l_q, rd_g_q;
	logic signed [SSW-1:0] qs_q;
	logic signed [LSW-1:0] ql_q;
	logic signed [EW-1:0]  ew1_q, ew2_q;
	logic signed [RW-1:0]  est_q, fresh_q, tmo_q;
	logic signed [RW-1:0]  est_o_q, fresh_o_q, tmo_o_q;
	logic                  full_o_q, sat_o_q;

	logic signed [RW-1:0] s_ring [SHORT_DEPTH];
	logic signed [RW-1:0] l_ring [LONG_DEPTH];
	logic signed [RW-1:0] g_ring [LONG_DEPTH];

	hat_pkg::unit_ctl_t               mul_ctl, div_ctl;
	logic                             mul_busy, divs_busy, divl_busy, divg_busy;
	logic [KW-1:0]                    mul_a;
	logic signed [hat_pkg::PROD_W-1:0] prod;
	logic signed [SSW-1:0]            qs;
	logic signed [LSW-1:0]            ql, qg;
	logic [SDW-1:0]                   ns;
	logic [LDW-1:0]                   nl, ng;
	logic signed [RW-1:0]             norm;
	logic                             s_old, l_old, accept, mul1_done, out_free;

	assign accept    = beat_in.valid && beat_in.ready;
	assign beat_in.ready = state_q == ST_IDLE;
	assign cfg.ready = 1'b1;
	assign out_free  = !out_valid_q || result_out.ready;
	assign mul1_done = state_q == ST_MUL1 && !mul_busy;
	assign s_old     = k_q >= KW'(SHORT_DEPTH);
	assign l_old     = k_q >= KW'(LONG_DEPTH);
	assign norm      = hat_pkg::sat48(64'(t_q) - 64'(prod));

	assign ns = (k_q < KW'(SHORT_DEPTH)) ? SDW'(k_q + 1'b1) : SDW'(SHORT_DEPTH);
	assign nl = (k_q < KW'(LONG_DEPTH)) ? LDW'(k_q + 1'b1) : LDW'(LONG_DEPTH);
	assign ng = (k_q < KW'(LONG_DEPTH)) ? LDW'(k_q) : LDW'(LONG_DEPTH);

	assign mul_ctl.start = state_q == ST_GAP || state_q == ST_MUL2S;
	assign mul_ctl.busy  = mul_busy;
	// dividers load the window sums the cycle after they are updated
	assign div_ctl.start = state_q == ST_DIVS;
	assign div_ctl.busy  = divs_busy || divl_busy || divg_busy;
	assign mul_a = (state_q == ST_MUL2S) ? k_q + 1'b1 : k_q;

	hat_mul u_mul (
		.clk, .arst_n, .ctl_in(mul_ctl), .busy(mul_busy),
		.a(mul_a), .b(mean_q), .prod
	);
	hat_div #(.NW(SSW), .DW(SDW)) u_div_s (
		.clk, .arst_n, .ctl_in(div_ctl), .busy(divs_busy), .num(ssum_q), .den(ns), .quo(qs)
	);
	hat_div #(.NW(LSW), .DW(LDW)) u_div_l (
		.clk, .arst_n, .ctl_in(div_ctl), .busy(divl_busy), .num(lsum_q), .den(nl), .quo(ql)
	);
	hat_div #(.NW(LSW), .DW(LDW)) u_div_g (
		.clk, .arst_n, .ctl_in(div_ctl), .busy(divg_busy), .num(gsum_q), .den(ng), .quo(qg)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			origin_q    <= '0;
			hb_ivl_q    <= hat_pkg::HB_INTERVAL_RST;
			margin_q    <= hat_pkg::SAFETY_MARGIN_RST;
			k_q         <= hat_pkg::K_NONE;
			idx_s_q     <= '0;
			idx_l_q     <= '0;
			last_q      <= '0;
			mean_q      <= '0;
			ssum_q      <= '0;
			lsum_q      <= '0;
			gsum_q      <= '0;
			full_q      <= 1'b0;
			sat_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg.valid) begin
				case (hat_pkg::cfg_idx_t'(cfg.index))
					hat_pkg::CFG_TIME_ORIGIN:   origin_q <= cfg.data;
					hat_pkg::CFG_HB_INTERVAL:   hb_ivl_q <= cfg.data[hat_pkg::IVL_W-1:0];
					hat_pkg::CFG_SAFETY_MARGIN: margin_q <= cfg.data[hat_pkg::IVL_W-1:0];
					default: ;
				endcase
			end
			if (state_q == ST_OUT && out_free) out_valid_q <= 1'b1;
			else if (result_out.valid && result_out.ready) out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						sat_q <= 1'b0;
						priority if (k_q == hat_pkg::K_NONE) begin
							k_q     <= '0;
							idx_s_q <= '0;
							idx_l_q <= '0;
						end else if (k_q == hat_pkg::K_MAX) begin
							sat_q <= 1'b1;
						end else begin
							k_q     <= k_q + 1'b1;
							idx_s_q <= (idx_s_q == SIW'(SHORT_DEPTH - 1)) ? '0 : idx_s_q + 1'b1;
							idx_l_q <= (idx_l_q == LIW'(LONG_DEPTH - 1)) ? '0 : idx_l_q + 1'b1;
						end
						state_q <= ST_GAP;
					end
				end
				ST_GAP: begin
					last_q  <= t_q;
					state_q <= ST_MUL1;
				end
				ST_MUL1: begin
					if (!mul_busy) begin
						ssum_q <= ssum_q - (s_old ? SSW'(rd_s_q) : '0) + SSW'(norm);
						lsum_q <= lsum_q - (l_old ? LSW'(rd_l_q) : '0) + LSW'(norm);
						gsum_q <= gsum_q - (l_old ? LSW'(rd_g_q) : '0) + LSW'(gap_q);
						if (s_old && l_old) full_q <= 1'b1;
						if (k_q == '0) begin
							mean_q  <= $signed({{(hat_pkg::MEAN_W-hat_pkg::IVL_W){1'b0}}, hb_ivl_q});
							state_q <= ST_FRESH;
						end else begin
							state_q <= ST_DIVS;
						end
					end
				end
				ST_DIVS: state_q <= ST_DIV;
				ST_DIV: begin
					if (!div_ctl.busy) begin
						mean_q  <= hat_pkg::sat32(64'(qg));
						state_q <= ST_MUL2S;
					end
				end
				ST_MUL2S: state_q <= ST_MUL2;
				ST_MUL2:  if (!mul_busy) state_q <= ST_EST;
				ST_EST:   state_q <= ST_FRESH;
				ST_FRESH: state_q <= ST_TMO;
				ST_TMO:   state_q <= ST_OUT;
				ST_OUT: begin
					if (out_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			t_q <= $signed({1'b0, beat_in.arrival_time}) - $signed({1'b0, origin_q});
		if (state_q == ST_GAP) gap_q <= hat_pkg::sat48(64'(t_q) - 64'(last_q));
		if (state_q == ST_DIV && !div_ctl.busy) begin
			qs_q <= qs;
			ql_q <= ql;
		end
		if (mul1_done && k_q == '0) est_q <= $signed({{(RW-hat_pkg::IVL_W){1'b0}}, hb_ivl_q});
		if (state_q == ST_MUL2 && !mul_busy) begin
			ew1_q <= EW'(qs_q) + EW'(prod);
			ew2_q <= EW'(ql_q) + EW'(prod);
		end
		if (state_q == ST_EST)
			est_q <= hat_pkg::sat48(64'(ew1_q > ew2_q ? ew1_q : ew2_q));
		if (state_q == ST_FRESH)
			fresh_q <= hat_pkg::sat48(64'(est_q) + $signed({40'd0, margin_q}));
		if (state_q == ST_TMO)
			tmo_q <= hat_pkg::sat48(64'(fresh_q) - 64'(t_q));
		if (state_q == ST_OUT && out_free) begin
			est_o_q   <= est_q;
			fresh_o_q <= fresh_q;
			tmo_o_q   <= tmo_q;
			full_o_q  <= full_q;
			sat_o_q   <= sat_q;
		end
	end

	// ring slots: old value read in ST_GAP, before the new one lands when the first multiply is done
	always_ff @(posedge clk) begin
		if (state_q == ST_GAP) begin
			rd_s_q <= s_ring[idx_s_q];
			rd_l_q <= l_ring[idx_l_q];
			rd_g_q <= g_ring[idx_l_q];
		end
		if (mul1_done) begin
			s_ring[idx_s_q] <= norm;
			l_ring[idx_l_q] <= norm;
			g_ring[idx_l_q] <= gap_q;
		end
	end

	assign result_out.valid             = out_valid_q;
	assign result_out.estimated_arrival = est_o_q;
	assign result_out.expiry_point      = fresh_o_q;
	assign result_out.remaining_timeout = tmo_o_q;
	assign result_out.windows_full      = full_o_q;
	assign result_out.index_saturated   = sat_o_q;
endmodule

[design/hat_checker.sv]
module hat_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             in_valid,
	input logic                             in_ready,
	input logic                             out_valid,
	input logic                             out_ready,
	input logic signed [hat_pkg::RES_W-1:0] est,
	input logic signed [hat_pkg::RES_W-1:0] fresh,
	input logic                             full,
	input logic                             sat
);
	logic [1:0] pend_q;
	logic       full_seen_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q      <= '0;
			full_seen_q <= 1'b0;
		end else begin
			pend_q <= pend_q + 2'((in_valid && in_ready) ? 1 : 0)
				- 2'((out_valid && out_ready) ? 1 : 0);
			if (out_valid && full) full_seen_q <= 1'b1;
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(est) && $stable(fresh))
		else $error("result beat dropped or changed while stalled");

	a_owed: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pend_q != 2'd0)
		else $error("result beat without an input beat");

	a_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && full_seen_q |-> full)
		else $error("windows_full fell");

	a_sat_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && sat |-> full)
		else $error("saturated index without full windows");

	a_margin: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> fresh >= est)
		else $error("expiry point below estimate");
endmodule

bind heartbeat_adaptive_timeout_unit hat_checker u_hat_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (beat_in.valid),
	.in_ready  (beat_in.ready),
	.out_valid (result_out.valid),
	.out_ready (result_out.ready),
	.est       (result_out.estimated_arrival),
	.fresh     (result_out.expiry_point),
	.full      (result_out.windows_full),
	.sat       (result_out.index_saturated)
);
